// ===== sv/hcac_pkg.sv =====
// package: widths, codes and transaction types shared by the auto-contrast block
package hcac_pkg;

   // histogram bin counter width; bins and the pixel total saturate at its maximum
   localparam int COUNT_BITS = 22;
   localparam int BIN_BITS   = 8;
   localparam int BINS       = 1 << BIN_BITS;
   // a running sum over all bins can exceed one counter by the bin count
   localparam int ACC_BITS   = COUNT_BITS + BIN_BITS;
   localparam int GAIN_BITS  = 24;
   localparam int FRAC_BITS  = 16;
   localparam int CLIP_BITS  = 14;
   localparam int DEN_BITS   = 15;
   localparam int MUL_A_BITS = (ACC_BITS > GAIN_BITS) ? ACC_BITS : GAIN_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + DEN_BITS;

   // scan counter: reads run 0..BINS-1, compares trail the reads through the ram, sum and product registers
   localparam int SCAN_BITS  = BIN_BITS + 1;
   localparam logic [SCAN_BITS-1:0] SCAN_LAST = SCAN_BITS'(BINS + 2);

   localparam logic [DEN_BITS-1:0]  CLIP_DEN   = DEN_BITS'(20000);
   localparam logic [CLIP_BITS-1:0] CLIP_RESET = CLIP_BITS'(100);
   localparam logic [GAIN_BITS-1:0] GAIN_NUM   = GAIN_BITS'(255 * 65536);
   localparam logic [GAIN_BITS-1:0] GAIN_MAX   = GAIN_BITS'(16711680);
   localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(65536);
   localparam logic [BIN_BITS-1:0]  PIX_MAX    = {BIN_BITS{1'b1}};

   localparam logic OP_COLLECT   = 1'b0;
   localparam logic OP_STRETCH   = 1'b1;
   localparam logic KIND_FRAME   = 1'b0;
   localparam logic KIND_STRETCH = 1'b1;

   typedef struct packed {
      logic                op;
      logic [BIN_BITS-1:0] pixel;
      logic                last;
   } req_type;

   typedef struct packed {
      logic                 result_kind;
      logic [BIN_BITS-1:0]  out_pixel;
      logic [BIN_BITS-1:0]  low_cut;
      logic [BIN_BITS-1:0]  high_cut;
      logic [GAIN_BITS-1:0] gain;
      logic                 flat_frame;
   } rsp_type;

endpackage

// ===== sv/hcac_ram.sv =====
// generic single-write, single-read ram with registered read data
module hcac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hcac_mul.sv =====
// shared unsigned multiplier with registered product
module hcac_mul (
   input  logic                           clock,
   input  logic [hcac_pkg::MUL_A_BITS-1:0] mul_a,
   input  logic [hcac_pkg::DEN_BITS-1:0]   mul_b,
   output logic [hcac_pkg::PROD_BITS-1:0]  prod
);

   logic [hcac_pkg::PROD_BITS-1:0] prod_ff;
   logic [hcac_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = hcac_pkg::PROD_BITS'(mul_a) * hcac_pkg::PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== sv/hcac_div.sv =====
// restoring divider, one quotient bit per cycle, for the gain computation
module hcac_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hcac_pkg::GAIN_BITS-1:0] dividend,
   input  logic [hcac_pkg::BIN_BITS-1:0]  divisor,
   output logic                           done,
   output logic [hcac_pkg::GAIN_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(hcac_pkg::GAIN_BITS + 1);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [CNT_BITS-1:0]            cnt_ff, cnt_in;
   logic [hcac_pkg::GAIN_BITS-1:0] quo_ff, quo_in;
   logic [hcac_pkg::BIN_BITS-1:0]  rem_ff, rem_in;
   logic [hcac_pkg::BIN_BITS-1:0]  div_ff, div_in;
   logic [hcac_pkg::BIN_BITS:0]    rem_sh;
   logic [hcac_pkg::BIN_BITS:0]    rem_diff;
   logic                           fits;

   assign rem_sh   = {rem_ff, quo_ff[hcac_pkg::GAIN_BITS-1]};
   assign fits     = rem_sh >= {1'b0, div_ff};
   assign rem_diff = rem_sh - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(hcac_pkg::GAIN_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[hcac_pkg::GAIN_BITS-2:0], fits};
         rem_in = fits ? rem_diff[hcac_pkg::BIN_BITS-1:0] : rem_sh[hcac_pkg::BIN_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/histogram_clip_auto_contrast_top.sv =====
// top level: histogram auto-contrast with clipped cuts, sequencer and datapath
//
// Gray pixels are collected into a 256-bin histogram held in one RAM; the
// collect transaction with last set closes the frame: one ascending pass over
// the RAM forms the running sum, finds the low cut (first bin whose running sum
// reaches total*clip/20000) and the high cut (one below the first bin whose
// running sum reaches total*(20000-clip)/20000), and zeroes every bin behind the
// read. With clip zero the frame minimum and maximum are used instead. The gain
// 255/(high-low) in Q8.16 comes from a bit-serial divider and a frame
// transaction reports the cuts; stretch transactions then map a sample with
// that gain. One transaction is worked on at a time and req_stall is high while
// it is busy. A collect reads and then writes its bin in the histogram RAM. A
// stretch passes the shared multiplier, then rounding and clamping. The frame
// close forms both limit products, runs the scan and, when the cuts are not
// flat, runs the divider. After reset a clearing pass zeroes the histogram
// RAM, during which no transaction is accepted; csr writes are taken at
// any time. A finished result waits in an output register, so the next
// transaction can start while it is stalled; only a new result waits for
// that register to empty.
module histogram_clip_auto_contrast_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  hcac_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output hcac_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hcac_pkg::CLIP_BITS-1:0] csr_data
);

   localparam int CB = hcac_pkg::COUNT_BITS;
   localparam int BB = hcac_pkg::BIN_BITS;
   localparam int AB = hcac_pkg::ACC_BITS;
   localparam int GB = hcac_pkg::GAIN_BITS;
   localparam int PB = hcac_pkg::PROD_BITS;
   localparam int SB = hcac_pkg::SCAN_BITS;

   // sequencer states
   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_COLLECT   = 4'd2;
   localparam logic [3:0] ST_STR_MUL   = 4'd3;
   localparam logic [3:0] ST_STR_OUT   = 4'd4;
   localparam logic [3:0] ST_LIM_LOW   = 4'd5;
   localparam logic [3:0] ST_LIM_HIGH  = 4'd6;
   localparam logic [3:0] ST_SCAN      = 4'd7;
   localparam logic [3:0] ST_DIV_START = 4'd8;
   localparam logic [3:0] ST_DIV_WAIT  = 4'd9;
   localparam logic [3:0] ST_FINISH    = 4'd10;

   // control state
   logic [3:0]                     state_ff, state_in;
   logic [SB-1:0]                  cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hcac_pkg::CLIP_BITS-1:0] clip_ff, clip_in;
   logic [CB-1:0]                  total_ff, total_in;
   logic [BB-1:0]                  min_ff, min_in;
   logic [BB-1:0]                  max_ff, max_in;
   logic [BB-1:0]                  low_level_ff, low_level_in;
   logic [GB-1:0]                  gain_ff, gain_in;
   logic                           found_lo_ff, found_lo_in;
   logic                           found_hi_ff, found_hi_in;

   // payload registers
   logic [BB-1:0]      pix_ff, pix_in;
   logic               last_ff, last_in;
   logic [AB-1:0]      acc_ff, acc_in;
   logic [PB-1:0]      lim_low_ff, lim_low_in;
   logic [PB-1:0]      lim_high_ff, lim_high_in;
   logic [BB-1:0]      scan_lo_ff, scan_lo_in;
   logic [BB-1:0]      scan_hi_ff, scan_hi_in;
   logic [BB-1:0]      cut_lo_ff, cut_lo_in;
   logic [BB-1:0]      cut_hi_ff, cut_hi_in;
   logic               flat_ff, flat_in;
   logic [GB-1:0]      new_gain_ff, new_gain_in;
   hcac_pkg::rsp_type  rsp_ff, rsp_in;

   // ram, multiplier and divider hookup
   logic                        ram_wr_en;
   logic [BB-1:0]               ram_wr_addr;
   logic [CB-1:0]               ram_wr_data;
   logic [BB-1:0]               ram_rd_addr;
   logic [CB-1:0]               ram_rd_data;
   logic [hcac_pkg::MUL_A_BITS-1:0] mul_a;
   logic [hcac_pkg::DEN_BITS-1:0]   mul_b;
   logic [PB-1:0]               prod;
   logic                        div_start;
   logic                        div_done;
   logic [GB-1:0]               div_quo;

   // helpers
   logic          req_accept;
   logic          out_free;
   logic          scan_data;
   logic          scan_cmp;
   logic [SB-1:0] clr_idx;
   logic [SB-1:0] cmp_idx;
   logic          cond_low;
   logic          cond_high;
   logic          clip_zero;
   logic [BB-1:0] sel_lo;
   logic [BB-1:0] sel_hi;
   logic          sel_flat;
   logic [BB-1:0] range_w;
   logic [GB-1:0] dividend;
   logic [BB-1:0] str_diff;
   logic [PB-1:0] str_rnd;
   logic [PB-1:0] str_shift;
   logic [BB-1:0] str_pix;
   logic [CB-1:0] bin_inc;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // scan pipeline: a read issued at count k is summed from the ram output, and its product is compared at cmp_idx k
   assign scan_data = (cnt_ff >= SB'(1)) && (cnt_ff <= SB'(hcac_pkg::BINS));
   assign scan_cmp  = cnt_ff >= SB'(3);
   assign clr_idx   = cnt_ff - SB'(1);
   assign cmp_idx   = cnt_ff - SB'(3);
   assign cond_low  = prod >= lim_low_ff;
   assign cond_high = prod >= lim_high_ff;

   // cut selection at the end of the scan
   assign clip_zero = clip_ff == '0;
   assign sel_lo    = clip_zero ? min_ff : scan_lo_ff;
   assign sel_hi    = clip_zero ? max_ff : scan_hi_ff;
   assign sel_flat  = sel_hi <= sel_lo;
   assign range_w   = sel_hi - sel_lo;
   // round half up: add half the divisor before dividing
   assign dividend  = hcac_pkg::GAIN_NUM + GB'(range_w >> 1);

   // stretch: samples at or below the low level map to zero
   assign str_diff  = (pix_ff > low_level_ff) ? (pix_ff - low_level_ff) : '0;
   assign str_rnd   = prod + PB'(1 << (hcac_pkg::FRAC_BITS - 1));
   assign str_shift = str_rnd >> hcac_pkg::FRAC_BITS;
   assign str_pix   = (str_shift > PB'(hcac_pkg::PIX_MAX)) ? hcac_pkg::PIX_MAX
                                                           : str_shift[BB-1:0];

   // saturating bin increment
   assign bin_inc = (ram_rd_data == {CB{1'b1}}) ? ram_rd_data : ram_rd_data + CB'(1);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_STR_MUL, ST_STR_OUT: begin
            // held through the output wait so the product stays put
            mul_a = hcac_pkg::MUL_A_BITS'(gain_ff);
            mul_b = hcac_pkg::DEN_BITS'(str_diff);
         end
         ST_LIM_LOW: begin
            mul_a = hcac_pkg::MUL_A_BITS'(total_ff);
            mul_b = hcac_pkg::DEN_BITS'(clip_ff);
         end
         ST_LIM_HIGH: begin
            mul_a = hcac_pkg::MUL_A_BITS'(total_ff);
            mul_b = hcac_pkg::CLIP_DEN - hcac_pkg::DEN_BITS'(clip_ff);
         end
         ST_SCAN: begin
            mul_a = hcac_pkg::MUL_A_BITS'(acc_ff);
            mul_b = hcac_pkg::CLIP_DEN;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // histogram ram port select
   always_comb begin
      ram_rd_addr = pix_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pix_ff;
      ram_wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[BB-1:0];
         end
         ST_IDLE: begin
            ram_rd_addr = req_data.pixel;
         end
         ST_COLLECT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = bin_inc;
         end
         ST_SCAN: begin
            ram_rd_addr = cnt_ff[BB-1:0];
            // zero each bin right after its data has been read
            ram_wr_en   = scan_data;
            ram_wr_addr = clr_idx[BB-1:0];
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      clip_in      = clip_ff;
      total_in     = total_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      low_level_in = low_level_ff;
      gain_in      = gain_ff;
      found_lo_in  = found_lo_ff;
      found_hi_in  = found_hi_ff;
      pix_in       = pix_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      lim_low_in   = lim_low_ff;
      lim_high_in  = lim_high_ff;
      scan_lo_in   = scan_lo_ff;
      scan_hi_in   = scan_hi_ff;
      cut_lo_in    = cut_lo_ff;
      cut_hi_in    = cut_hi_ff;
      flat_in      = flat_ff;
      new_gain_in  = new_gain_ff;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;

      if (csr_valid && csr_ready) begin
         clip_in = csr_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == SB'(hcac_pkg::BINS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + SB'(1);
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               pix_in  = req_data.pixel;
               last_in = req_data.last;
               if (req_data.op == hcac_pkg::OP_STRETCH) begin
                  state_in = ST_STR_MUL;
               end else begin
                  if (total_ff != {CB{1'b1}}) begin
                     total_in = total_ff + CB'(1);
                  end
                  if (req_data.pixel < min_ff) begin
                     min_in = req_data.pixel;
                  end
                  if (req_data.pixel > max_ff) begin
                     max_in = req_data.pixel;
                  end
                  state_in = ST_COLLECT;
               end
            end
         end
         ST_COLLECT: begin
            state_in = last_ff ? ST_LIM_LOW : ST_IDLE;
         end
         ST_STR_MUL: begin
            state_in = ST_STR_OUT;
         end
         ST_STR_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = hcac_pkg::KIND_STRETCH;
               rsp_in.out_pixel   = str_pix;
               rsp_in.low_cut     = '0;
               rsp_in.high_cut    = '0;
               rsp_in.gain        = '0;
               rsp_in.flat_frame  = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         ST_LIM_LOW: begin
            acc_in      = '0;
            found_lo_in = 1'b0;
            found_hi_in = 1'b0;
            scan_lo_in  = '0;
            scan_hi_in  = hcac_pkg::PIX_MAX;
            state_in    = ST_LIM_HIGH;
         end
         ST_LIM_HIGH: begin
            lim_low_in = prod;
            cnt_in     = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (cnt_ff == '0) begin
               lim_high_in = prod;
            end
            if (scan_data) begin
               acc_in = acc_ff + AB'(ram_rd_data);
            end
            if (scan_cmp) begin
               // low cut: first bin reaching the low limit, top bin as ceiling
               if (!found_lo_ff && (cond_low || cmp_idx[BB-1:0] == hcac_pkg::PIX_MAX)) begin
                  found_lo_in = 1'b1;
                  scan_lo_in  = cmp_idx[BB-1:0];
               end
               // high cut: one below the first bin reaching the high limit, floor zero
               if (!found_hi_ff && cond_high) begin
                  found_hi_in = 1'b1;
                  scan_hi_in  = (cmp_idx[BB-1:0] == '0) ? '0 : cmp_idx[BB-1:0] - BB'(1);
               end
            end
            if (cnt_ff == hcac_pkg::SCAN_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV_START;
            end else begin
               cnt_in = cnt_ff + SB'(1);
            end
         end
         ST_DIV_START: begin
            cut_lo_in = sel_lo;
            cut_hi_in = sel_hi;
            flat_in   = sel_flat;
            if (sel_flat) begin
               new_gain_in = hcac_pkg::GAIN_MAX;
               state_in    = ST_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               new_gain_in = div_quo;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_kind = hcac_pkg::KIND_FRAME;
               rsp_in.out_pixel   = '0;
               rsp_in.low_cut     = cut_lo_ff;
               rsp_in.high_cut    = cut_hi_ff;
               rsp_in.gain        = new_gain_ff;
               rsp_in.flat_frame  = flat_ff;
               low_level_in       = cut_lo_ff;
               gain_in            = new_gain_ff;
               // frame statistics restart; the bins were zeroed by the scan
               total_in           = '0;
               min_in             = hcac_pkg::PIX_MAX;
               max_in             = '0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         clip_ff      <= hcac_pkg::CLIP_RESET;
         total_ff     <= '0;
         min_ff       <= hcac_pkg::PIX_MAX;
         max_ff       <= '0;
         low_level_ff <= '0;
         gain_ff      <= hcac_pkg::GAIN_UNITY;
         found_lo_ff  <= 1'b0;
         found_hi_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         clip_ff      <= clip_in;
         total_ff     <= total_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         low_level_ff <= low_level_in;
         gain_ff      <= gain_in;
         found_lo_ff  <= found_lo_in;
         found_hi_ff  <= found_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      last_ff     <= last_in;
      acc_ff      <= acc_in;
      lim_low_ff  <= lim_low_in;
      lim_high_ff <= lim_high_in;
      scan_lo_ff  <= scan_lo_in;
      scan_hi_ff  <= scan_hi_in;
      cut_lo_ff   <= cut_lo_in;
      cut_hi_ff   <= cut_hi_in;
      flat_ff     <= flat_in;
      new_gain_ff <= new_gain_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   hcac_ram #(
      .WIDTH (CB),
      .DEPTH (hcac_pkg::BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hcac_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   hcac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (range_w),
      .done     (div_done),
      .quotient (div_quo)
   );

endmodule

// ===== sv/hcac_checker.sv =====
// port-level checker for the auto-contrast block, bound to the top level
module hcac_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hcac_pkg::rsp_type rsp_data
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   // every accepted transaction takes the sequencer out of idle and raises req_stall
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted on two consecutive cycles");

   // stretch results carry no frame statistics
   a_stretch_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == hcac_pkg::KIND_STRETCH |->
         rsp_data.low_cut == '0 && rsp_data.high_cut == '0 &&
         rsp_data.gain == '0 && !rsp_data.flat_frame)
      else $error("stretch result with nonzero statistics fields");

   // frame flag agrees with the cuts, and a flat frame saturates the gain
   a_frame_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == hcac_pkg::KIND_FRAME |->
         rsp_data.out_pixel == '0 &&
         rsp_data.flat_frame == (rsp_data.high_cut <= rsp_data.low_cut) &&
         (!rsp_data.flat_frame || rsp_data.gain == hcac_pkg::GAIN_MAX))
      else $error("frame result inconsistent with its cuts");

   // a real range never exceeds 255 levels, so the gain is at least unity
   a_frame_gain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == hcac_pkg::KIND_FRAME &&
         !rsp_data.flat_frame |-> rsp_data.gain >= hcac_pkg::GAIN_UNITY)
      else $error("frame gain below unity");

endmodule

bind histogram_clip_auto_contrast_top hcac_checker u_hcac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
